/* rtl/core/gcs_pkg.sv */
// Shared types and constants for the GRU cell step block.
`default_nettype none

package gcs_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    // Gate indices in the parameter layout
    localparam logic [1:0] GATE_R = 2'd0;
    localparam logic [1:0] GATE_Z = 2'd1;
    localparam logic [1:0] GATE_N = 2'd2;

    localparam int ACC_W = 42;              // Q.24 accumulators
    localparam int PRE_W = ACC_W + 17;      // preactivation incl. r * (W_hn h + b_hn)
    localparam int FIDX_W = 3;              // feature index, up to six features

    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ACT,
        ST_RNH,
        ST_NEW,
        ST_MIX,
        ST_UPD,
        ST_BIAS,
        ST_FIN
    } state_t;

    // Multiplier operand source
    typedef enum logic [1:0] {
        OP_FEAT,
        OP_HID,
        OP_ONE,
        OP_HNEW
    } op_t;

    // Accumulator destination
    typedef enum logic [2:0] {
        DST_R,
        DST_Z,
        DST_NI,
        DST_NH,
        DST_P
    } dest_t;

    typedef struct packed {
        op_t               op;
        dest_t             dest;
        logic [FIDX_W-1:0] fidx;
        logic              hval;
    } term_t;

endpackage

`default_nettype wire

/* rtl/core/gcs_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/gru_cell_step.sv */
// GRU cell step: parameter store, hidden vector, shared MAC sequencer and head.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | func, param_addr, param_value, feat_0..feat_5
//  out     | out_valid | out_stall | prediction
//
// Load and clear requests are applied in the cycle they are accepted. A step request
// runs from acceptance to the prediction on the single MAC, which reads one parameter
// word a cycle; per hidden entry it then drains the MAC pipeline and steps through
// the activation/update states ACT, RNH, NEW, MIX and UPD. Reset clears the hidden
// vector through per-entry valid bits; the parameter store is undefined until loaded.
// in_stall is high while a step is running; a finished prediction waits in the output
// register and holds the sequencer at its last state only if the previous prediction
// has not been taken.
`default_nettype none

module gru_cell_step
    import gcs_pkg::*;
#(
    parameter int HID_UNITS       = 16,
    parameter int FEATURE_COUNT   = 6,
    parameter int PARAM_DEPTH     = 2048,
    parameter int ACT_TABLE_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [10:0]        param_addr,
    input  wire logic signed [15:0] param_value,
    input  wire logic signed [15:0] feat_0,
    input  wire logic signed [15:0] feat_1,
    input  wire logic signed [15:0] feat_2,
    input  wire logic signed [15:0] feat_3,
    input  wire logic signed [15:0] feat_4,
    input  wire logic signed [15:0] feat_5,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      prediction
);

    localparam int AW     = $clog2(PARAM_DEPTH);
    localparam int HIW    = (HID_UNITS > 1) ? $clog2(HID_UNITS) : 1;
    localparam int HDEPTH = 2 * (1 << HIW);
    localparam int FIW    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int TERMS  = FEATURE_COUNT + HID_UNITS + 2;
    localparam int TW     = $clog2(TERMS);
    localparam int TIW    = $clog2(ACT_TABLE_DEPTH);
    localparam int DW     = $clog2(ACT_TABLE_DEPTH + 1);
    localparam int PAW    = (AW > 11) ? AW + 1 : 12;

    // Parameter layout
    localparam int OFF_WHH = 3 * HID_UNITS * FEATURE_COUNT;
    localparam int OFF_BIH = OFF_WHH + 3 * HID_UNITS * HID_UNITS;
    localparam int OFF_BHH = OFF_BIH + 3 * HID_UNITS;
    localparam int OFF_FCW = OFF_BHH + 3 * HID_UNITS;
    localparam int OFF_FCB = OFF_FCW + HID_UNITS;

    localparam logic [AW-1:0] WI_BASE [3] = '{
        AW'(0),
        AW'((HID_UNITS * FEATURE_COUNT) % PARAM_DEPTH),
        AW'((2 * HID_UNITS * FEATURE_COUNT) % PARAM_DEPTH)};
    localparam logic [AW-1:0] WH_BASE [3] = '{
        AW'(OFF_WHH % PARAM_DEPTH),
        AW'((OFF_WHH + HID_UNITS * HID_UNITS) % PARAM_DEPTH),
        AW'((OFF_WHH + 2 * HID_UNITS * HID_UNITS) % PARAM_DEPTH)};
    localparam logic [AW-1:0] BI_BASE [3] = '{
        AW'(OFF_BIH % PARAM_DEPTH),
        AW'((OFF_BIH + HID_UNITS) % PARAM_DEPTH),
        AW'((OFF_BIH + 2 * HID_UNITS) % PARAM_DEPTH)};
    localparam logic [AW-1:0] BH_BASE [3] = '{
        AW'(OFF_BHH % PARAM_DEPTH),
        AW'((OFF_BHH + HID_UNITS) % PARAM_DEPTH),
        AW'((OFF_BHH + 2 * HID_UNITS) % PARAM_DEPTH)};
    localparam logic [AW-1:0] FW_BASE  = AW'(OFF_FCW % PARAM_DEPTH);
    localparam logic [AW-1:0] FCB_ADDR = AW'(OFF_FCB % PARAM_DEPTH);

    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint HALF_Q30  = 64'sd536870912;
    localparam longint EIGHT_Q30 = 64'sd8589934592;

    localparam logic signed [PRE_W-1:0] RND_Q12 = PRE_W'(2048);
    localparam logic signed [PRE_W-1:0] OFS_EIGHT = PRE_W'(64'sd134217728);
    localparam logic signed [PRE_W-1:0] OFS_SIXTEEN = PRE_W'(64'sd268435456);

    // ---------------------------------------------------------------
    // Elaboration-time helpers for the activation tables
    // ---------------------------------------------------------------
    function automatic longint udiv(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // exp(-a) in Q.30: Taylor series of exp(-a/256), squared eight times
    function automatic longint exp_neg_q30(input longint a);
        longint y;
        longint term;
        longint sum;
        y = a >>> 8;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int n = 1; n <= 6; n++)
        begin
            term = udiv((term * y + HALF_Q30) >>> 30, longint'(n));
            if ((n % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 8; k++)
        begin
            sum = (sum * sum + HALF_Q30) >>> 30;
        end
        return sum;
    endfunction

    function automatic logic [15:0] act_entry(input int k, input bit is_tanh);
        longint x;
        longint a;
        longint e;
        longint num;
        longint den;
        longint q;
        x = (longint'(2 * k + 1) * EIGHT_Q30) / ACT_TABLE_DEPTH - EIGHT_Q30;
        a = (x < 0) ? -x : x;
        if (is_tanh)
        begin
            e = exp_neg_q30(2 * a);
            num = ONE_Q30 - e;
            den = ONE_Q30 + e;
            q = udiv(num * 4096 + (den >>> 1), den);
            if (x < 0)
            begin
                q = -q;
            end
        end
        else
        begin
            e = exp_neg_q30(a);
            num = (x >= 0) ? ONE_Q30 : e;
            den = ONE_Q30 + e;
            q = udiv(num * 4096 + (den >>> 1), den);
        end
        return q[15:0];
    endfunction

    // Preactivation (Q.24) to table index, clamped to the table
    function automatic logic [TIW-1:0] tab_idx(input logic signed [PRE_W-1:0] p);
        logic signed [PRE_W-1:0] t;
        logic [28+DW-1:0]        scaled;
        t = p + OFS_EIGHT;
        scaled = (28 + DW)'(t[27:0]) * (28 + DW)'(ACT_TABLE_DEPTH);
        if (t <= 0)
        begin
            return '0;
        end
        else if (t >= OFS_SIXTEEN)
        begin
            return TIW'(ACT_TABLE_DEPTH - 1);
        end
        return scaled[28 +: TIW];
    endfunction

    function automatic logic signed [15:0] rnd_sat(input logic signed [PRE_W-1:0] v);
        logic signed [PRE_W-1:0] s;
        s = (v + RND_Q12) >>> 12;
        if (s > PRE_W'(32767))
        begin
            return 16'sd32767;
        end
        else if (s < -PRE_W'(32768))
        begin
            return -16'sd32768;
        end
        return s[15:0];
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW:0] b);
        logic [AW+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s >= (AW + 2)'(PARAM_DEPTH))
        begin
            s = s - (AW + 2)'(PARAM_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Activation tables (constant)
    // ---------------------------------------------------------------
    logic [15:0] sig_tab  [ACT_TABLE_DEPTH];
    logic [15:0] tanh_tab [ACT_TABLE_DEPTH];

    for (genvar k = 0; k < ACT_TABLE_DEPTH; k++)
    begin : g_tab
        localparam logic [15:0] SIG_V  = act_entry(k, 1'b0);
        localparam logic [15:0] TANH_V = act_entry(k, 1'b1);
        assign sig_tab[k]  = SIG_V;
        assign tanh_tab[k] = TANH_V;
    end

    // ---------------------------------------------------------------
    // Signals
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [1:0]     g_reg;
    logic [TW-1:0]  t_reg;
    logic [HIW-1:0] h_reg;
    logic           bank_reg;
    logic           hvalid_reg [HDEPTH];

    logic [AW-1:0] ptr_wi_reg [3];
    logic [AW-1:0] ptr_wh_reg [3];
    logic [AW-1:0] ptr_bi_reg [3];
    logic [AW-1:0] ptr_bh_reg [3];
    logic [AW-1:0] ptr_fw_reg;

    logic signed [15:0] x_reg [FEATURE_COUNT];
    logic signed [15:0] feat_in [6];

    logic               s1_valid_reg;
    term_t              s1_term_reg;
    logic               s2_valid_reg;
    dest_t              s2_dest_reg;
    logic signed [31:0] prod_reg;

    logic signed [ACC_W-1:0] acc_r_reg, acc_z_reg, acc_ni_reg, acc_nh_reg, acc_p_reg;
    logic signed [15:0]      r_reg, z_reg, n_reg, hnew_reg;
    logic signed [ACC_W+15:0] rnh_reg;
    logic signed [33:0]      m1_reg, m2_reg;

    logic signed [15:0]      pred_reg;
    logic                    out_valid_reg;

    // memory ports
    logic              prm_we;
    logic [AW-1:0]     prm_waddr;
    logic [AW-1:0]     prm_raddr;
    logic [15:0]       prm_rdata;
    logic              hid_we;
    logic [HIW:0]      hid_waddr;
    logic [HIW:0]      hid_raddr;
    logic [15:0]       hid_rdata;

    logic              in_acc;
    logic              pipe_empty;
    logic              out_free;
    logic              fin_done;
    logic              issue;
    term_t             issue_term;
    logic [HIW-1:0]    hj;
    logic [PAW-1:0]    load_addr;
    logic signed [15:0] b_op;
    logic signed [15:0] hnew_c;
    logic signed [PRE_W-1:0] pre_n;
    logic signed [ACC_W+15:0] rnh_rnd;

    assign feat_in[0] = feat_0;
    assign feat_in[1] = feat_1;
    assign feat_in[2] = feat_2;
    assign feat_in[3] = feat_3;
    assign feat_in[4] = feat_4;
    assign feat_in[5] = feat_5;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && (state_reg == ST_IDLE);
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign fin_done   = pipe_empty && out_free;
    assign out_valid  = out_valid_reg;
    assign prediction = pred_reg;
    assign load_addr  = PAW'(param_addr);

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    gcs_ram #(
        .WIDTH (16),
        .DEPTH (PARAM_DEPTH)
    ) u_prm_ram (
        .clk   (clk),
        .we    (prm_we),
        .waddr (prm_waddr),
        .wdata (param_value),
        .raddr (prm_raddr),
        .rdata (prm_rdata)
    );

    // two banks: old hidden vector read, new one written, bank flips per step
    gcs_ram #(
        .WIDTH (16),
        .DEPTH (HDEPTH)
    ) u_hid_ram (
        .clk   (clk),
        .we    (hid_we),
        .waddr (hid_waddr),
        .wdata (hnew_c),
        .raddr (hid_raddr),
        .rdata (hid_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (func == FUNC_STEP))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if ((t_reg == TW'(TERMS - 1)) && (g_reg == GATE_N))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:  state_next = ST_RNH;
            ST_RNH:  state_next = ST_NEW;
            ST_NEW:  state_next = ST_MIX;
            ST_MIX:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (h_reg == HIW'(HID_UNITS - 1))
                begin
                    state_next = ST_BIAS;
                end
                else
                begin
                    state_next = ST_MAC;
                end
            end
            ST_BIAS: state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: memory addresses and term issue
    // ---------------------------------------------------------------
    assign hj = HIW'(t_reg - TW'(FEATURE_COUNT + 1));

    always_comb
    begin
        prm_we     = 1'b0;
        prm_waddr  = load_addr[AW-1:0];
        prm_raddr  = FCB_ADDR;
        hid_we     = 1'b0;
        hid_waddr  = {!bank_reg, h_reg};
        hid_raddr  = {bank_reg, h_reg};
        issue      = 1'b0;
        issue_term = '{op: OP_ONE, dest: DST_P, fidx: '0, hval: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (func == FUNC_LOAD) && (load_addr < PAW'(PARAM_DEPTH)))
                begin
                    prm_we = 1'b1;
                end
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (g_reg == GATE_R)
                begin
                    issue_term.dest = DST_R;
                end
                else if (g_reg == GATE_Z)
                begin
                    issue_term.dest = DST_Z;
                end
                else if (t_reg <= TW'(FEATURE_COUNT))
                begin
                    issue_term.dest = DST_NI;
                end
                else
                begin
                    issue_term.dest = DST_NH;
                end
                if (t_reg < TW'(FEATURE_COUNT))
                begin
                    prm_raddr       = wrap_add(ptr_wi_reg[g_reg], (AW + 1)'(t_reg));
                    issue_term.op   = OP_FEAT;
                    issue_term.fidx = FIDX_W'(t_reg);
                end
                else if (t_reg == TW'(FEATURE_COUNT))
                begin
                    prm_raddr = ptr_bi_reg[g_reg];
                end
                else if (t_reg <= TW'(FEATURE_COUNT + HID_UNITS))
                begin
                    prm_raddr       = wrap_add(ptr_wh_reg[g_reg], (AW + 1)'(hj));
                    hid_raddr       = {bank_reg, hj};
                    issue_term.op   = OP_HID;
                    issue_term.hval = hvalid_reg[{bank_reg, hj}];
                end
                else
                begin
                    prm_raddr = ptr_bh_reg[g_reg];
                end
            end
            ST_UPD:
            begin
                // write h' and queue its head product
                hid_we        = 1'b1;
                issue         = 1'b1;
                prm_raddr     = ptr_fw_reg;
                issue_term.op = OP_HNEW;
            end
            ST_BIAS:
            begin
                issue     = 1'b1;
                prm_raddr = FCB_ADDR;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g_reg         <= GATE_R;
            t_reg         <= '0;
            h_reg         <= '0;
            bank_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HDEPTH; i++)
            begin
                hvalid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if ((state_reg == ST_FIN) && fin_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    g_reg <= GATE_R;
                    t_reg <= '0;
                    h_reg <= '0;
                    if (in_acc && (func == FUNC_CLEAR))
                    begin
                        for (int i = 0; i < HDEPTH; i++)
                        begin
                            hvalid_reg[i] <= 1'b0;
                        end
                    end
                end
                ST_MAC:
                begin
                    if (t_reg == TW'(TERMS - 1))
                    begin
                        t_reg <= '0;
                        g_reg <= (g_reg == GATE_N) ? GATE_R : g_reg + 2'd1;
                    end
                    else
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end
                ST_UPD:
                begin
                    hvalid_reg[hid_waddr] <= 1'b1;
                    h_reg <= h_reg + HIW'(1);
                end
                ST_FIN:
                begin
                    if (fin_done)
                    begin
                        bank_reg <= !bank_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        case (s1_term_reg.op)
            OP_FEAT: b_op = x_reg[s1_term_reg.fidx[FIW-1:0]];
            OP_HID:  b_op = s1_term_reg.hval ? $signed(hid_rdata) : 16'sd0;
            OP_ONE:  b_op = ONE_Q12;
            OP_HNEW: b_op = hnew_reg;
            default: b_op = 16'sd0;
        endcase
    end

    assign rnh_rnd = (rnh_reg + (ACC_W + 16)'(2048)) >>> 12;
    assign pre_n   = PRE_W'(acc_ni_reg) + PRE_W'($signed(rnh_rnd));
    assign hnew_c  = rnd_sat(PRE_W'(m1_reg) + PRE_W'(m2_reg));

    always_ff @(posedge clk)
    begin
        // MAC pipeline: operand select and multiply, then accumulate
        s1_term_reg <= issue_term;
        prod_reg    <= $signed(prm_rdata) * b_op;
        s2_dest_reg <= s1_term_reg.dest;

        if (s2_valid_reg)
        begin
            case (s2_dest_reg)
                DST_R:   acc_r_reg  <= acc_r_reg  + ACC_W'(prod_reg);
                DST_Z:   acc_z_reg  <= acc_z_reg  + ACC_W'(prod_reg);
                DST_NI:  acc_ni_reg <= acc_ni_reg + ACC_W'(prod_reg);
                DST_NH:  acc_nh_reg <= acc_nh_reg + ACC_W'(prod_reg);
                DST_P:   acc_p_reg  <= acc_p_reg  + ACC_W'(prod_reg);
                default: acc_p_reg  <= acc_p_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < FEATURE_COUNT; i++)
                begin
                    x_reg[i] <= feat_in[i];
                end
                for (int g = 0; g < 3; g++)
                begin
                    ptr_wi_reg[g] <= WI_BASE[g];
                    ptr_wh_reg[g] <= WH_BASE[g];
                    ptr_bi_reg[g] <= BI_BASE[g];
                    ptr_bh_reg[g] <= BH_BASE[g];
                end
                ptr_fw_reg <= FW_BASE;
                acc_r_reg  <= '0;
                acc_z_reg  <= '0;
                acc_ni_reg <= '0;
                acc_nh_reg <= '0;
                acc_p_reg  <= '0;
            end
            ST_ACT:
            begin
                r_reg <= $signed(sig_tab[tab_idx(PRE_W'(acc_r_reg))]);
                z_reg <= $signed(sig_tab[tab_idx(PRE_W'(acc_z_reg))]);
            end
            ST_RNH:
            begin
                rnh_reg <= r_reg * acc_nh_reg;
            end
            ST_NEW:
            begin
                n_reg <= $signed(tanh_tab[tab_idx(pre_n)]);
            end
            ST_MIX:
            begin
                // (1 - z) * n and z * h, with h from the old bank
                m1_reg <= (17'sd4096 - 17'(z_reg)) * n_reg;
                m2_reg <= z_reg * (hvalid_reg[{bank_reg, h_reg}] ?
                                   $signed(hid_rdata) : 16'sd0);
                acc_r_reg  <= '0;
                acc_z_reg  <= '0;
                acc_ni_reg <= '0;
                acc_nh_reg <= '0;
            end
            ST_UPD:
            begin
                hnew_reg <= hnew_c;
                for (int g = 0; g < 3; g++)
                begin
                    ptr_wi_reg[g] <= wrap_add(ptr_wi_reg[g], (AW + 1)'(FEATURE_COUNT));
                    ptr_wh_reg[g] <= wrap_add(ptr_wh_reg[g], (AW + 1)'(HID_UNITS));
                    ptr_bi_reg[g] <= wrap_add(ptr_bi_reg[g], (AW + 1)'(1));
                    ptr_bh_reg[g] <= wrap_add(ptr_bh_reg[g], (AW + 1)'(1));
                end
                ptr_fw_reg <= wrap_add(ptr_fw_reg, (AW + 1)'(1));
            end
            ST_FIN:
            begin
                if (fin_done)
                begin
                    pred_reg <= rnd_sat(PRE_W'(acc_p_reg));
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // gate results are only taken once every queued product has landed
    a_drained_before_act: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACT) |-> pipe_empty)
        else $error("activation read with products still in flight");

    // new hidden values never overwrite the bank being read
    a_hid_bank: assert property (@(posedge clk) disable iff (!rst_n)
        hid_we |-> (hid_waddr[HIW] != bank_reg))
        else $error("hidden write into the live bank");

    // a prediction appears only on completion of a step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("prediction raised outside step completion");

    // parameter writes only from load requests while idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        prm_we |-> (state_reg == ST_IDLE) && in_valid && (func == FUNC_LOAD))
        else $error("parameter write outside a load request");

    // the bank flips exactly when a prediction is produced
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> out_valid_reg)
        else $error("hidden bank flipped without a prediction");
`endif

endmodule

`default_nettype wire
